// ----- rtl/apts_pkg.sv -----
// ----------------------------------------------------------------------------
// Aging priority task scheduler package
// Shared constants for the scheduler: state codes, operation modes, status codes.
// ----------------------------------------------------------------------------
package apts_pkg;

	localparam int unsigned TableSlotsDefault = 64;
	localparam int unsigned IdW = 31;
	localparam int unsigned LevelW = 3;
	localparam int unsigned WaitW = 10;
	localparam int unsigned TagW = 16;
	localparam int unsigned SlotW = 6;

	localparam logic [2:0] ST_UNUSED = 3'd0;
	localparam logic [2:0] ST_SLEEPING = 3'd2;
	localparam logic [2:0] ST_RUNNABLE = 3'd3;
	localparam logic [2:0] ST_RUNNING = 3'd4;

	localparam logic [2:0] MODE_AGE = 3'd0;
	localparam logic [2:0] MODE_SELECT = 3'd1;
	localparam logic [2:0] MODE_CREATE = 3'd2;
	localparam logic [2:0] MODE_YIELD = 3'd3;
	localparam logic [2:0] MODE_SLEEP = 3'd4;
	localparam logic [2:0] MODE_WAKEUP = 3'd5;
	localparam logic [2:0] MODE_NICE = 3'd6;
	localparam logic [2:0] MODE_FREE = 3'd7;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_NONE = 2'd1;
	localparam logic [1:0] STAT_BADLVL = 2'd2;

	localparam logic [2:0] LEVEL_MAX = 3'd4;
	localparam logic [2:0] LEVEL_DEFAULT = 3'd2;
	localparam logic [9:0] AGING_RESET = 10'd50;
	localparam logic [30:0] ID_MAX = 31'h7FFF_FFFF;

endpackage

// ----- rtl/aging_priority_task_scheduler.sv -----
// ----------------------------------------------------------------------------
// Aging priority task scheduler
// Task table with aging, priority select, create, yield, sleep, wakeup,
// set-nice and free, processed one slot per cycle by a small sequencer.
// ----------------------------------------------------------------------------
//  Channel   Signals                                        Direction
//  input     in_valid, in_stall, mode slot task_id level channel   in
//  output    out_valid, out_stall, status out_slot out_id old_level out
//  config    cfg_valid, cfg_ready, cfg_data                 in
//
// Age, select, create, wakeup and set-nice walk the whole table one slot per
// cycle through one shared compare/update unit while in_stall stays high;
// select then writes the winner back at the end. Yield, sleep and free read
// and update only the addressed slot, and a create or set-nice with an
// invalid level goes straight to the result without a table walk. After
// reset a clearing pass resets the table while in_stall is high. The result
// moves to its own output register; a finished request waits in its last
// state while the previous result has not been taken.
module aging_priority_task_scheduler #(
	parameter int unsigned TABLE_SLOTS = apts_pkg::TableSlotsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [5:0]  slot,
	input  logic [30:0] task_id,
	input  logic [2:0]  level,
	input  logic [15:0] channel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [5:0]  out_slot,
	output logic [30:0] out_id,
	output logic [2:0]  old_level,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data
);

	localparam int unsigned IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
	localparam logic [CW-1:0] LAST = CW'(TABLE_SLOTS - 1);

	typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_READ, S_SCAN, S_FINISH, S_OUT} state_t;

	// One table row; stored as one memory word.
	typedef struct packed {
		logic [2:0]  st;
		logic [30:0] id;
		logic [2:0]  base;
		logic [2:0]  eff;
		logic [9:0]  waitc;
		logic [15:0] tag;
	} entry_t;

	entry_t mem [TABLE_SLOTS];
	entry_t rd_q;

	state_t      state_q;
	logic [CW-1:0] idx_q;
	logic [2:0]  mode_q;
	logic [5:0]  slot_q;
	logic [30:0] tid_q;
	logic [2:0]  lvl_q;
	logic [15:0] chan_q;
	logic [9:0]  aging_q;
	logic [30:0] next_id_q;
	logic        have_q;
	logic [IW-1:0] best_q;
	logic [2:0]  best_eff_q;
	logic [30:0] best_id_q;
	entry_t      best_ent_q;
	logic        found_q;
	logic [1:0]  status_q;
	logic [5:0]  oslot_q;
	logic [30:0] oid_q;
	logic [2:0]  old_q;
	logic        ovalid_q;
	logic [1:0]  rstat_q;
	logic [5:0]  rslot_q;
	logic [30:0] rid_q;
	logic [2:0]  rold_q;

	logic          we;
	logic [IW-1:0] waddr;
	entry_t        wdata;
	logic [IW-1:0] raddr;
	logic [CW-1:0] idx_n;
	logic          slot_ok;
	logic [9:0]    wplus;
	entry_t        clr;
	logic          better;

	assign in_stall = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = ovalid_q;
	assign status = rstat_q;
	assign out_slot = rslot_q;
	assign out_id = rid_q;
	assign old_level = rold_q;

	assign slot_ok = ({2'b00, slot_q} < 8'(TABLE_SLOTS)) || (TABLE_SLOTS > 64);
	assign idx_n = idx_q + CW'(1);
	assign wplus = rd_q.waitc + 10'd1;
	assign better = !have_q || (rd_q.eff < best_eff_q) ||
		((rd_q.eff == best_eff_q) && (rd_q.id < best_id_q));

	always_comb begin
		clr = '{st: apts_pkg::ST_UNUSED, id: '0, base: apts_pkg::LEVEL_DEFAULT,
			eff: apts_pkg::LEVEL_DEFAULT, waitc: '0, tag: '0};
	end

	// Read address: table walk index, or the addressed slot, or the winner.
	always_comb begin
		raddr = idx_q[IW-1:0];
		if (mode_q == apts_pkg::MODE_YIELD || mode_q == apts_pkg::MODE_SLEEP ||
			mode_q == apts_pkg::MODE_FREE) begin
			raddr = IW'(slot_q);
		end else if (mode_q == apts_pkg::MODE_SELECT && state_q == S_FINISH) begin
			raddr = best_q;
		end
	end

	// Shared update unit: one entry in, one entry out.
	always_comb begin
		we = 1'b0;
		waddr = raddr;
		wdata = rd_q;
		if (state_q == S_CLEAR) begin
			we = 1'b1;
			waddr = idx_q[IW-1:0];
			wdata = clr;
		end else if (state_q == S_SCAN) begin
			waddr = idx_q[IW-1:0] - IW'(1);
			case (mode_q)
				apts_pkg::MODE_AGE: begin
					if (rd_q.st == apts_pkg::ST_RUNNABLE) begin
						we = 1'b1;
						if (wplus >= aging_q) begin
							wdata.waitc = '0;
							if (rd_q.eff != 3'd0) begin
								wdata.eff = rd_q.eff - 3'd1;
							end
						end else begin
							wdata.waitc = wplus;
						end
					end
				end
				apts_pkg::MODE_CREATE: begin
					if (!found_q && rd_q.st == apts_pkg::ST_UNUSED) begin
						we = 1'b1;
						wdata = '{st: apts_pkg::ST_RUNNABLE, id: next_id_q, base: lvl_q,
							eff: lvl_q, waitc: '0, tag: '0};
					end
				end
				apts_pkg::MODE_WAKEUP: begin
					if (rd_q.st == apts_pkg::ST_SLEEPING && rd_q.tag == chan_q) begin
						we = 1'b1;
						wdata.st = apts_pkg::ST_RUNNABLE;
						wdata.waitc = '0;
					end
				end
				apts_pkg::MODE_NICE: begin
					if (!found_q && rd_q.st != apts_pkg::ST_UNUSED && rd_q.id == tid_q) begin
						we = 1'b1;
						wdata.base = lvl_q;
						wdata.eff = lvl_q;
						wdata.waitc = '0;
					end
				end
				default: begin
				end
			endcase
		end else if (state_q == S_FINISH) begin
			waddr = raddr;
			case (mode_q)
				apts_pkg::MODE_SELECT: begin
					if (have_q) begin
						we = 1'b1;
						wdata = best_ent_q;
						wdata.st = apts_pkg::ST_RUNNING;
					end
				end
				apts_pkg::MODE_YIELD, apts_pkg::MODE_SLEEP: begin
					if (slot_ok && rd_q.st == apts_pkg::ST_RUNNING) begin
						we = 1'b1;
						wdata.st = (mode_q == apts_pkg::MODE_YIELD) ?
							apts_pkg::ST_RUNNABLE : apts_pkg::ST_SLEEPING;
						if (mode_q == apts_pkg::MODE_SLEEP) begin
							wdata.tag = chan_q;
						end
						wdata.eff = rd_q.base;
						wdata.waitc = '0;
					end
				end
				apts_pkg::MODE_FREE: begin
					if (slot_ok && rd_q.st != apts_pkg::ST_UNUSED) begin
						we = 1'b1;
						wdata = clr;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			idx_q <= '0;
			aging_q <= apts_pkg::AGING_RESET;
			next_id_q <= 31'd1;
			ovalid_q <= 1'b0;
			have_q <= 1'b0;
			found_q <= 1'b0;
			mode_q <= apts_pkg::MODE_AGE;
			status_q <= apts_pkg::STAT_OK;
			oslot_q <= '0;
			oid_q <= '0;
			old_q <= '0;
			rstat_q <= apts_pkg::STAT_OK;
			rslot_q <= '0;
			rid_q <= '0;
			rold_q <= '0;
			slot_q <= '0;
			tid_q <= '0;
			lvl_q <= '0;
			chan_q <= '0;
			best_q <= '0;
			best_eff_q <= '0;
			best_id_q <= '0;
			best_ent_q <= '0;
		end else begin
			if (cfg_valid) begin
				aging_q <= cfg_data;
			end
			if (ovalid_q && !out_stall) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					idx_q <= idx_n;
					if (idx_q == LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						mode_q <= mode;
						slot_q <= slot;
						tid_q <= task_id;
						lvl_q <= level;
						chan_q <= channel;
						idx_q <= '0;
						have_q <= 1'b0;
						found_q <= 1'b0;
						status_q <= apts_pkg::STAT_NONE;
						oslot_q <= '0;
						oid_q <= '0;
						old_q <= '0;
						if ((mode == apts_pkg::MODE_CREATE || mode == apts_pkg::MODE_NICE) &&
							level > apts_pkg::LEVEL_MAX) begin
							status_q <= apts_pkg::STAT_BADLVL;
							state_q <= S_OUT;
						end else begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					idx_q <= idx_n;
					if (mode_q == apts_pkg::MODE_YIELD || mode_q == apts_pkg::MODE_SLEEP ||
						mode_q == apts_pkg::MODE_FREE) begin
						state_q <= S_FINISH;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// rd_q holds the entry at idx_q - 1.
					case (mode_q)
						apts_pkg::MODE_AGE: status_q <= apts_pkg::STAT_OK;
						apts_pkg::MODE_SELECT: begin
							if (rd_q.st == apts_pkg::ST_RUNNABLE && better) begin
								have_q <= 1'b1;
								best_q <= idx_q[IW-1:0] - IW'(1);
								best_eff_q <= rd_q.eff;
								best_id_q <= rd_q.id;
								best_ent_q <= rd_q;
							end
						end
						apts_pkg::MODE_CREATE: begin
							if (!found_q && rd_q.st == apts_pkg::ST_UNUSED) begin
								found_q <= 1'b1;
								status_q <= apts_pkg::STAT_OK;
								oslot_q <= 6'(idx_q - CW'(1));
								oid_q <= next_id_q;
								if (next_id_q != apts_pkg::ID_MAX) begin
									next_id_q <= next_id_q + 31'd1;
								end
							end
						end
						apts_pkg::MODE_WAKEUP: begin
							if (rd_q.st == apts_pkg::ST_SLEEPING && rd_q.tag == chan_q) begin
								status_q <= apts_pkg::STAT_OK;
							end
						end
						apts_pkg::MODE_NICE: begin
							if (!found_q && rd_q.st != apts_pkg::ST_UNUSED &&
								rd_q.id == tid_q) begin
								found_q <= 1'b1;
								status_q <= apts_pkg::STAT_OK;
								oslot_q <= 6'(idx_q - CW'(1));
								oid_q <= rd_q.id;
								old_q <= rd_q.base;
							end
						end
						default: begin
						end
					endcase
					if (idx_q == CW'(TABLE_SLOTS)) begin
						state_q <= (mode_q == apts_pkg::MODE_SELECT) ? S_FINISH : S_OUT;
					end else begin
						idx_q <= idx_n;
					end
				end
				S_FINISH: begin
					// Select: the winner is written back here; else the addressed slot.
					if (mode_q == apts_pkg::MODE_SELECT) begin
						if (have_q) begin
							status_q <= apts_pkg::STAT_OK;
							oslot_q <= 6'(best_q);
							oid_q <= best_id_q;
						end
					end else if (mode_q == apts_pkg::MODE_FREE) begin
						if (slot_ok && rd_q.st != apts_pkg::ST_UNUSED) begin
							status_q <= apts_pkg::STAT_OK;
						end
					end else if (slot_ok && rd_q.st == apts_pkg::ST_RUNNING) begin
						status_q <= apts_pkg::STAT_OK;
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!ovalid_q) begin
						ovalid_q <= 1'b1;
						rstat_q <= status_q;
						rslot_q <= oslot_q;
						rid_q <= oid_q;
						rold_q <= old_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Aging priority task scheduler testbench
// Drives requests from a directed table and then random task-life sequences,
// predicts each result from a local copy of the task table, and checks it.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

	localparam int NSLOT = 64;
	localparam int QUIET_LIMIT = 20000;

	typedef struct packed {
		logic [2:0]  mode;
		logic [5:0]  slot;
		logic [30:0] task_id;
		logic [2:0]  level;
		logic [15:0] channel;
	} request_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [5:0]  out_slot;
		logic [30:0] out_id;
		logic [2:0]  old_level;
	} reply_t;

	typedef struct {
		request_t req;
		bit       typed;
		reply_t   rep;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] mode = '0;
	logic [5:0] slot = '0;
	logic [30:0] task_id = '0;
	logic [2:0] level = '0;
	logic [15:0] channel = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [5:0] out_slot;
	logic [30:0] out_id;
	logic [2:0] old_level;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [9:0] cfg_data = '0;

	aging_priority_task_scheduler dut (.*);

	always #5 clk = ~clk;

	// Shadow of the task table.
	logic [2:0]  t_state [NSLOT];
	logic [30:0] t_id [NSLOT];
	logic [2:0]  t_base [NSLOT];
	logic [2:0]  t_eff [NSLOT];
	logic [9:0]  t_wait [NSLOT];
	logic [15:0] t_tag [NSLOT];
	logic [30:0] id_next;
	logic [9:0]  interval;

	reply_t pending_replies[$];
	row_t directed[$];
	int errors = 0;
	int accepted = 0;
	int replies_seen = 0;
	int quiet = 0;
	bit gaps_on = 1'b1;
	int mode_hits[8];

	function automatic reply_t schedule_step(request_t r);
		reply_t o;
		int best;
		logic [10:0] w;
		o = '0;
		o.status = apts_pkg::STAT_NONE;
		best = -1;
		case (r.mode)
			apts_pkg::MODE_AGE: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (t_state[i] == apts_pkg::ST_RUNNABLE) begin
						w = t_wait[i] + 11'd1;
						if (w >= interval) begin
							if (t_eff[i] > 0) t_eff[i]--;
							w = '0;
						end
						t_wait[i] = w[9:0];
					end
				end
				o.status = apts_pkg::STAT_OK;
			end
			apts_pkg::MODE_SELECT: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (t_state[i] == apts_pkg::ST_RUNNABLE) begin
						if (best < 0 || t_eff[i] < t_eff[best] ||
								(t_eff[i] == t_eff[best] && t_id[i] < t_id[best]))
							best = i;
					end
				end
				if (best >= 0) begin
					t_state[best] = apts_pkg::ST_RUNNING;
					o.status = apts_pkg::STAT_OK;
					o.out_slot = 6'(best);
					o.out_id = t_id[best];
				end
			end
			apts_pkg::MODE_CREATE: begin
				if (r.level > apts_pkg::LEVEL_MAX) begin
					o.status = apts_pkg::STAT_BADLVL;
				end else begin
					for (int i = 0; i < NSLOT; i++) begin
						if (t_state[i] == apts_pkg::ST_UNUSED) begin
							t_state[i] = apts_pkg::ST_RUNNABLE;
							t_id[i] = id_next;
							t_base[i] = r.level;
							t_eff[i] = r.level;
							t_wait[i] = '0;
							t_tag[i] = '0;
							if (id_next < apts_pkg::ID_MAX) id_next++;
							o.status = apts_pkg::STAT_OK;
							o.out_slot = 6'(i);
							o.out_id = t_id[i];
							break;
						end
					end
				end
			end
			apts_pkg::MODE_YIELD, apts_pkg::MODE_SLEEP: begin
				if (t_state[r.slot] == apts_pkg::ST_RUNNING) begin
					if (r.mode == apts_pkg::MODE_YIELD) begin
						t_state[r.slot] = apts_pkg::ST_RUNNABLE;
					end else begin
						t_state[r.slot] = apts_pkg::ST_SLEEPING;
						t_tag[r.slot] = r.channel;
					end
					t_eff[r.slot] = t_base[r.slot];
					t_wait[r.slot] = '0;
					o.status = apts_pkg::STAT_OK;
				end
			end
			apts_pkg::MODE_WAKEUP: begin
				for (int i = 0; i < NSLOT; i++) begin
					if (t_state[i] == apts_pkg::ST_SLEEPING && t_tag[i] == r.channel) begin
						t_state[i] = apts_pkg::ST_RUNNABLE;
						t_wait[i] = '0;
						o.status = apts_pkg::STAT_OK;
					end
				end
			end
			apts_pkg::MODE_NICE: begin
				if (r.level > apts_pkg::LEVEL_MAX) begin
					o.status = apts_pkg::STAT_BADLVL;
				end else begin
					for (int i = 0; i < NSLOT; i++) begin
						if (t_state[i] != apts_pkg::ST_UNUSED && t_id[i] == r.task_id) begin
							o.old_level = t_base[i];
							t_base[i] = r.level;
							t_eff[i] = r.level;
							t_wait[i] = '0;
							o.status = apts_pkg::STAT_OK;
							o.out_slot = 6'(i);
							o.out_id = t_id[i];
							break;
						end
					end
				end
			end
			default: begin
				if (t_state[r.slot] != apts_pkg::ST_UNUSED) begin
					t_state[r.slot] = apts_pkg::ST_UNUSED;
					t_id[r.slot] = '0;
					t_base[r.slot] = apts_pkg::LEVEL_DEFAULT;
					t_eff[r.slot] = apts_pkg::LEVEL_DEFAULT;
					t_wait[r.slot] = '0;
					t_tag[r.slot] = '0;
					o.status = apts_pkg::STAT_OK;
				end
			end
		endcase
		return o;
	endfunction

	task automatic send_request(request_t r, bit typed, reply_t rep);
		reply_t predicted;
		while (gaps_on && $urandom_range(99) < 35) @(negedge clk);
		in_valid <= 1'b1;
		{mode, slot, task_id, level, channel} <= r;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predicted = schedule_step(r);
		if (typed && predicted != rep) begin
			errors++;
			$error("directed row mismatch: mode %0d table %h typed %h", r.mode, predicted, rep);
		end
		pending_replies.push_back(typed ? rep : predicted);
		mode_hits[r.mode]++;
		accepted++;
		@(negedge clk);
		in_valid <= 1'b0;
		// The block stalls right after taking the request, so nothing is lost here.
		@(negedge clk);
	endtask

	task automatic drain_and_wait();
		while (pending_replies.size() != 0) @(negedge clk);
		repeat (NSLOT + 10) @(negedge clk);
	endtask

	task automatic write_interval(logic [9:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		interval = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic request_t make_req(logic [2:0] m, logic [5:0] s, logic [30:0] id,
			logic [2:0] l, logic [15:0] c);
		request_t r;
		r = {m, s, id, l, c};
		return r;
	endfunction

	function automatic reply_t make_rep(logic [1:0] st, logic [5:0] s, logic [30:0] id,
			logic [2:0] ol);
		reply_t o;
		o = {st, s, id, ol};
		return o;
	endfunction

	function automatic request_t random_req();
		request_t r;
		int live [$];
		int pick;
		r = {3'($urandom_range(7)), 6'($urandom), 31'($urandom), 3'($urandom_range(4)),
			16'($urandom_range(3))};
		for (int i = 0; i < NSLOT; i++) if (t_state[i] != apts_pkg::ST_UNUSED) live.push_back(i);
		pick = $urandom_range(99);
		// Mostly well-formed operations on live tasks; the rest is noise.
		if (live.size() != 0 && pick < 75) begin
			r.slot = 6'(live[$urandom_range(live.size() - 1)]);
			r.task_id = t_id[r.slot];
		end
		if (pick >= 95) r.level = 3'($urandom_range(7));
		if (pick >= 97) r.channel = 16'($urandom);
		if (live.size() < 20 && $urandom_range(3) == 0) r.mode = apts_pkg::MODE_CREATE;
		return r;
	endfunction

	// Sink side: random stall and checking.
	always @(negedge clk) begin
		if (arst_n) out_stall <= gaps_on ? ($urandom_range(99) < 35) : 1'b0;
	end

	always @(posedge clk) begin
		reply_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {status, out_slot, out_id, old_level};
			replies_seen++;
			if (pending_replies.size() == 0) begin
				errors++;
				$error("reply without a pending request: %h", got);
			end else begin
				want = pending_replies.pop_front();
				if (got.status != want.status) begin
					errors++;
					$error("status expected %0d actual %0d", want.status, got.status);
				end
				if (got.out_slot != want.out_slot) begin
					errors++;
					$error("out_slot expected %0d actual %0d", want.out_slot, got.out_slot);
				end
				if (got.out_id != want.out_id) begin
					errors++;
					$error("out_id expected %0d actual %0d", want.out_id, got.out_id);
				end
				if (got.old_level != want.old_level) begin
					errors++;
					$error("old_level expected %0d actual %0d", want.old_level,
						got.old_level);
				end
			end
		end
	end

	// Watchdog on cycles with no handshake.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < NSLOT; i++) begin
			t_state[i] = apts_pkg::ST_UNUSED;
			t_id[i] = '0;
			t_base[i] = apts_pkg::LEVEL_DEFAULT;
			t_eff[i] = apts_pkg::LEVEL_DEFAULT;
			t_wait[i] = '0;
			t_tag[i] = '0;
		end
		id_next = 31'd1;
		interval = apts_pkg::AGING_RESET;

		// Empty table after reset, invalid levels, then a short task life.
		directed.push_back('{make_req(apts_pkg::MODE_SELECT, 0, 0, 0, 0), 1,
			make_rep(apts_pkg::STAT_NONE, 0, 0, 0)});
		directed.push_back('{make_req(apts_pkg::MODE_AGE, 0, 0, 0, 0), 1,
			make_rep(apts_pkg::STAT_OK, 0, 0, 0)});
		directed.push_back('{make_req(apts_pkg::MODE_WAKEUP, 0, 0, 0, 16'hFFFF), 1,
			make_rep(apts_pkg::STAT_NONE, 0, 0, 0)});
		directed.push_back('{make_req(apts_pkg::MODE_FREE, 63, 0, 0, 0), 1,
			make_rep(apts_pkg::STAT_NONE, 0, 0, 0)});
		directed.push_back('{make_req(apts_pkg::MODE_YIELD, 63, 0, 0, 0), 1,
			make_rep(apts_pkg::STAT_NONE, 0, 0, 0)});
		directed.push_back('{make_req(apts_pkg::MODE_SLEEP, 0, 0, 0, 0), 1,
			make_rep(apts_pkg::STAT_NONE, 0, 0, 0)});
		directed.push_back('{make_req(apts_pkg::MODE_CREATE, 0, 0, 7, 0), 1,
			make_rep(apts_pkg::STAT_BADLVL, 0, 0, 0)});
		directed.push_back('{make_req(apts_pkg::MODE_NICE, 0, 31'h7FFFFFFF, 5, 0), 1,
			make_rep(apts_pkg::STAT_BADLVL, 0, 0, 0)});
		directed.push_back('{make_req(apts_pkg::MODE_NICE, 0, 31'h7FFFFFFF, 0, 0), 1,
			make_rep(apts_pkg::STAT_NONE, 0, 0, 0)});
		directed.push_back('{make_req(apts_pkg::MODE_CREATE, 0, 0, 4, 0), 1,
			make_rep(apts_pkg::STAT_OK, 0, 1, 0)});
		directed.push_back('{make_req(apts_pkg::MODE_CREATE, 0, 0, 0, 0), 1,
			make_rep(apts_pkg::STAT_OK, 1, 2, 0)});
		directed.push_back('{make_req(apts_pkg::MODE_CREATE, 0, 0, 0, 0), 0, '0});
		directed.push_back('{make_req(apts_pkg::MODE_SELECT, 0, 0, 0, 0), 0, '0});
		directed.push_back('{make_req(apts_pkg::MODE_SLEEP, 1, 0, 0, 16'hFFFF), 0, '0});
		directed.push_back('{make_req(apts_pkg::MODE_SELECT, 0, 0, 0, 0), 0, '0});
		directed.push_back('{make_req(apts_pkg::MODE_YIELD, 2, 0, 0, 0), 0, '0});
		directed.push_back('{make_req(apts_pkg::MODE_NICE, 0, 1, 0, 0), 0, '0});
		directed.push_back('{make_req(apts_pkg::MODE_WAKEUP, 0, 0, 0, 16'hFFFF), 0, '0});
		directed.push_back('{make_req(apts_pkg::MODE_AGE, 0, 0, 0, 0), 0, '0});
		directed.push_back('{make_req(apts_pkg::MODE_FREE, 0, 0, 0, 0), 0, '0});
		directed.push_back('{make_req(apts_pkg::MODE_SELECT, 0, 0, 0, 0), 0, '0});

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[k]) send_request(directed[k].req, directed[k].typed, directed[k].rep);
		drain_and_wait();

		// Random phases, each under its own aging interval.
		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: write_interval(10'd1);
				1: write_interval(10'd1023);
				2: write_interval(10'd3);
				3: write_interval(10'($urandom_range(1, 8)));
				default: write_interval(10'd0);
			endcase
			gaps_on = (phase != 2);
			for (int n = 0; n < 190; n++) begin
				send_request(random_req(), 1'b0, '0);
				if (n == 100) drain_and_wait();
			end
			gaps_on = 1'b1;
			drain_and_wait();
		end

		$display("Covered %0d requests, %0d replies; per mode: %0d %0d %0d %0d %0d %0d %0d %0d",
			accepted, replies_seen, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3],
			mode_hits[4], mode_hits[5], mode_hits[6], mode_hits[7]);
		if (errors == 0 && pending_replies.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- aging_priority_task_scheduler.f -----
rtl/apts_pkg.sv
rtl/aging_priority_task_scheduler.sv
test/tb.sv
